[design/lmss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the scrolling LED matrix scanner.
// No dependencies; imported by lmss_line_store and led_matrix_scroll_scanner_core.

package lmss_pkg;

    localparam int COLUMNS            = 8;
    localparam int COL_W              = 3;
    localparam int BYTE_W             = 8;
    localparam int MAX_LINE           = 256;
    localparam int LEN_W              = 9;
    localparam int CFG_IDX_W          = 3;
    localparam int DEFAULT_LINE_DEPTH = 256;
    localparam int INIT_SPEED         = 10;

    // config reset values
    localparam logic [LEN_W-1:0]  RST_LINE_LENGTH = 9'd8;
    localparam logic              RST_PAGE_MODE   = 1'b0;
    localparam logic [BYTE_W-1:0] RST_SPEED_MIN   = 8'd1;
    localparam logic [BYTE_W-1:0] RST_SPEED_MAX   = 8'd50;
    localparam logic [BYTE_W-1:0] RST_SPEED_STEP  = 8'd1;
    localparam logic              RST_ACT_LEVEL   = 1'b0;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_SPEED = 2'd2,
        OP_RUN   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_LENGTH = 3'd0,
        CFG_PAGE_MODE   = 3'd1,
        CFG_SPEED_MIN   = 3'd2,
        CFG_SPEED_MAX   = 3'd3,
        CFG_SPEED_STEP  = 3'd4,
        CFG_ACT_LEVEL   = 3'd5
    } cfg_idx_t;

    // data codes of speed and run state commands
    localparam logic [BYTE_W-1:0] SPD_DEC    = 8'd0;
    localparam logic [BYTE_W-1:0] SPD_INC    = 8'd1;
    localparam logic [BYTE_W-1:0] RUN_STOP   = 8'd0;
    localparam logic [BYTE_W-1:0] RUN_RESUME = 8'd1;

endpackage

`default_nettype wire

[design/led_matrix_scroll_scanner_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Scrolling 8x8 LED matrix column-multiplex scanner, top level.
// Depends on lmss_pkg and lmss_line_store.
//
// Input channel (in_valid/in_ready) carries op, address, data. Every input beat
// yields exactly one output beat (out_valid/out_ready), in order. A tick beat
// drives one column with the row byte read from the line store; load, speed
// and run state beats return a blank result carrying the current scroll base.
// Config port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and
// must only be written while the block is idle.
//
// An accepted beat passes through the read stage, which holds the synchronous
// line store read, and then the output register. One beat is accepted per
// cycle while the output is drained. A stalled output stops the input only
// once both the read stage and the output register are full. Reset clears the
// scan counters, the scroll base and the run state and loads the default speed
// and config; the line store is not cleared and reads of never-written
// entries are undefined.

module led_matrix_scroll_scanner_core
    import lmss_pkg::*;
#(
    parameter int LINE_DEPTH = DEFAULT_LINE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           op,
    input  wire logic [BYTE_W-1:0]    address,
    input  wire logic [BYTE_W-1:0]    data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      column_enable,
    output logic      [COL_W-1:0]     column_select,
    output logic                      column_level,
    output logic      [BYTE_W-1:0]    row_bits,
    output logic      [BYTE_W-1:0]    scroll_position,
    output logic                      sequence_done,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data
);

    localparam int MEM_DEPTH = (LINE_DEPTH < MAX_LINE) ? LINE_DEPTH : MAX_LINE;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int IDX_W     = BYTE_W + COL_W;   // page base * 8 + column

    // config registers
    logic [LEN_W-1:0]  line_length_reg;
    logic              page_mode_reg;
    logic [BYTE_W-1:0] speed_min_reg;
    logic [BYTE_W-1:0] speed_max_reg;
    logic [BYTE_W-1:0] speed_step_reg;
    logic              act_level_reg;

    // scan state
    logic [BYTE_W-1:0] base_reg,  base_next;
    logic [COL_W-1:0]  col_reg,   col_next;
    logic [BYTE_W-1:0] frame_reg, frame_next;
    logic [BYTE_W-1:0] speed_reg, speed_next;
    logic              paused_reg, paused_next;

    // read stage
    logic              s1_valid_reg;
    logic              s1_en_reg;
    logic [COL_W-1:0]  s1_sel_reg;
    logic              s1_level_reg;
    logic [BYTE_W-1:0] s1_pos_reg;
    logic              s1_done_reg;
    logic              s1_hit_reg;

    // output register
    logic              out_valid_reg;
    logic              out_en_reg;
    logic [COL_W-1:0]  out_sel_reg;
    logic              out_level_reg;
    logic [BYTE_W-1:0] out_row_reg;
    logic [BYTE_W-1:0] out_pos_reg;
    logic              out_done_reg;

    op_t               op_in;
    logic              in_accept;
    logic              is_tick;
    logic              s1_move;
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  positions;
    logic [IDX_W-1:0]  start_idx;
    logic [IDX_W-1:0]  col_idx;
    logic              in_range;
    logic [BYTE_W-1:0] speed_eff;
    logic [BYTE_W:0]   frame_inc;
    logic [BYTE_W:0]   base_inc;
    logic [BYTE_W:0]   speed_sum;
    logic              done_next;
    logic              load_en;
    logic [BYTE_W-1:0] rd_data;

    assign op_in     = op_t'(op);
    assign in_accept = in_valid && in_ready;
    assign is_tick   = (op_in == OP_TICK);
    assign s1_move   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= RST_LINE_LENGTH;
            page_mode_reg   <= RST_PAGE_MODE;
            speed_min_reg   <= RST_SPEED_MIN;
            speed_max_reg   <= RST_SPEED_MAX;
            speed_step_reg  <= RST_SPEED_STEP;
            act_level_reg   <= RST_ACT_LEVEL;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LINE_LENGTH: line_length_reg <= cfg_data;
                CFG_PAGE_MODE:   page_mode_reg   <= cfg_data[0];
                CFG_SPEED_MIN:   speed_min_reg   <= cfg_data[BYTE_W-1:0];
                CFG_SPEED_MAX:   speed_max_reg   <= cfg_data[BYTE_W-1:0];
                CFG_SPEED_STEP:  speed_step_reg  <= cfg_data[BYTE_W-1:0];
                CFG_ACT_LEVEL:   act_level_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // column address and frame bookkeeping
    always_comb
    begin
        if (line_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (line_length_reg > LEN_W'(MAX_LINE))
            eff_len = LEN_W'(MAX_LINE);
        else
            eff_len = line_length_reg;

        // pages = ceil(len / 8); len + 7 still fits in LEN_W bits
        positions = page_mode_reg ? ((eff_len + LEN_W'(COLUMNS - 1)) >> COL_W) : eff_len;

        start_idx = page_mode_reg ? {base_reg, {COL_W{1'b0}}}
                                  : {{COL_W{1'b0}}, base_reg};
        col_idx   = start_idx + {{BYTE_W{1'b0}}, col_reg};
        in_range  = (col_idx < IDX_W'(eff_len)) && (32'(col_idx) < LINE_DEPTH);

        speed_eff = (speed_reg == '0) ? BYTE_W'(1) : speed_reg;
        frame_inc = {1'b0, frame_reg} + (BYTE_W+1)'(1);
        base_inc  = {1'b0, base_reg} + (BYTE_W+1)'(1);
        speed_sum = {1'b0, speed_reg} + {1'b0, speed_step_reg};
    end

    always_comb
    begin
        base_next   = base_reg;
        col_next    = col_reg;
        frame_next  = frame_reg;
        speed_next  = speed_reg;
        paused_next = paused_reg;
        done_next   = 1'b0;

        if (in_accept)
        begin
            case (op_in)
                OP_TICK:
                begin
                    col_next = col_reg + COL_W'(1);
                    if (col_reg == COL_W'(COLUMNS - 1))
                    begin
                        if (frame_inc >= {1'b0, speed_eff})
                        begin
                            frame_next = '0;
                            if (!paused_reg)
                            begin
                                if (base_inc >= positions)
                                begin
                                    base_next = '0;
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    base_next = base_inc[BYTE_W-1:0];
                                end
                            end
                        end
                        else
                        begin
                            frame_next = frame_inc[BYTE_W-1:0];
                        end
                    end
                end
                OP_SPEED:
                begin
                    if (data == SPD_DEC)
                    begin
                        if (speed_reg > speed_min_reg)
                            speed_next = (speed_reg > speed_step_reg)
                                       ? (speed_reg - speed_step_reg) : '0;
                    end
                    else if (data == SPD_INC)
                    begin
                        if (speed_reg < speed_max_reg)
                            speed_next = speed_sum[BYTE_W] ? '1 : speed_sum[BYTE_W-1:0];
                    end
                end
                OP_RUN:
                begin
                    if (data == RUN_STOP)
                        paused_next = 1'b1;
                    else if (data == RUN_RESUME)
                        paused_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            col_reg    <= '0;
            frame_reg  <= '0;
            speed_reg  <= BYTE_W'(INIT_SPEED);
            paused_reg <= 1'b0;
        end
        else
        begin
            base_reg   <= base_next;
            col_reg    <= col_next;
            frame_reg  <= frame_next;
            speed_reg  <= speed_next;
            paused_reg <= paused_next;
        end
    end

    // A load writes at its accept edge, so a tick accepted next cycle sees it.
    assign load_en = in_accept && (op_in == OP_LOAD) && (32'(address) < LINE_DEPTH);

    lmss_line_store #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (address[AW-1:0]),
        .wr_data (data),
        .rd_en   (in_accept && is_tick),
        .rd_addr (col_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    // read stage and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_en_reg    <= is_tick;
            s1_sel_reg   <= is_tick ? col_reg : '0;
            s1_level_reg <= is_tick ? act_level_reg : !act_level_reg;
            s1_pos_reg   <= base_reg;
            s1_done_reg  <= done_next;
            s1_hit_reg   <= is_tick && in_range;
        end
        if (s1_move)
        begin
            out_en_reg    <= s1_en_reg;
            out_sel_reg   <= s1_sel_reg;
            out_level_reg <= s1_level_reg;
            out_row_reg   <= s1_hit_reg ? rd_data : '0;
            out_pos_reg   <= s1_pos_reg;
            out_done_reg  <= s1_done_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign column_enable   = out_en_reg;
    assign column_select   = out_sel_reg;
    assign column_level    = out_level_reg;
    assign row_bits        = out_row_reg;
    assign scroll_position = out_pos_reg;
    assign sequence_done   = out_done_reg;

    // checks
    a_done_on_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sequence_done |-> column_enable && column_select == COL_W'(COLUMNS - 1))
        else $error("wrap flagged off the last column of a frame");

    a_blank_non_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !column_enable |-> row_bits == '0 && column_select == '0)
        else $error("non-tick result carries column data");

    a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && is_tick |=> col_reg == COL_W'($past(col_reg) + COL_W'(1)))
        else $error("column counter did not advance on tick");

    a_hold_non_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !is_tick |=> $stable(col_reg) && $stable(frame_reg) && $stable(base_reg))
        else $error("scan state moved on a non-tick beat");

endmodule

`default_nettype wire

[design/lmss_line_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// Message line store: one write port, one registered read port.
// Depends on lmss_pkg.

module lmss_line_store
    import lmss_pkg::*;
#(
    parameter int DEPTH = DEFAULT_LINE_DEPTH,
    parameter int AW    = $clog2(DEFAULT_LINE_DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [BYTE_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low, so a stalled beat keeps its byte
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[tb/tb_led_matrix_scroll_scanner_core.sv]
`timescale 1ns / 1ps
// Self-checking bench for led_matrix_scroll_scanner_core: scan ticks, loads, speed and run
// commands are checked beat by beat against a tracker of the scroll state.
// Depends on lmss_pkg and the core RTL.

module tb_led_matrix_scroll_scanner_core;
    import lmss_pkg::*;

    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  sel;
        logic              lvl;
        logic [BYTE_W-1:0] rows;
        logic [BYTE_W-1:0] pos;
        logic              done;
    } column_drive_t;

    // Tracks scroll state and holds the column drives still owed by the core.
    class scan_tracker;
        logic [BYTE_W-1:0] line_copy [DEFAULT_LINE_DEPTH];
        int unsigned       base, col, frames, speed;
        bit                paused;
        int unsigned       line_len, page, spd_min, spd_max, spd_step;
        bit                act_level;
        column_drive_t     drive_queue [$];
        int unsigned       mismatches;

        function new();
            base       = 0;
            col        = 0;
            frames     = 0;
            speed      = INIT_SPEED;
            paused     = 1'b0;
            line_len   = 32'(RST_LINE_LENGTH);
            page       = 32'(RST_PAGE_MODE);
            spd_min    = 32'(RST_SPEED_MIN);
            spd_max    = 32'(RST_SPEED_MAX);
            spd_step   = 32'(RST_SPEED_STEP);
            act_level  = RST_ACT_LEVEL;
            mismatches = 0;
        endfunction

        function int unsigned shown_len(int unsigned code);
            if (code == 0)
                return 1;
            if (code > MAX_LINE)
                return MAX_LINE;
            return code;
        endfunction

        function int unsigned pending();
            return drive_queue.size();
        endfunction

        function void set_reg(cfg_idx_t idx, logic [LEN_W-1:0] val);
            case (idx)
                CFG_LINE_LENGTH: line_len  = 32'(val);
                CFG_PAGE_MODE:   page      = 32'(val[0]);
                CFG_SPEED_MIN:   spd_min   = 32'(val[BYTE_W-1:0]);
                CFG_SPEED_MAX:   spd_max   = 32'(val[BYTE_W-1:0]);
                CFG_SPEED_STEP:  spd_step  = 32'(val[BYTE_W-1:0]);
                CFG_ACT_LEVEL:   act_level = val[0];
                default: ;
            endcase
        endfunction

        function void note_item(op_t kind, logic [BYTE_W-1:0] addr, logic [BYTE_W-1:0] dat);
            column_drive_t d;
            int unsigned   eff, start, idx, reps, positions;
            eff    = shown_len(line_len);
            d.en   = 1'b0;
            d.sel  = '0;
            d.lvl  = ~act_level;
            d.rows = '0;
            d.pos  = 8'(base);
            d.done = 1'b0;
            case (kind)
                OP_TICK: begin
                    start     = page ? base * COLUMNS : base;
                    idx       = start + col;
                    reps      = (speed == 0) ? 1 : speed;
                    positions = page ? (eff + 7) / 8 : eff;
                    d.en      = 1'b1;
                    d.sel     = 3'(col);
                    d.lvl     = act_level;
                    d.rows    = (idx < eff) ? line_copy[idx] : '0;
                    col       = (col + 1) % COLUMNS;
                    if (col == 0) begin
                        frames++;
                        if (frames >= reps) begin
                            frames = 0;
                            // paused display keeps counting frames, base holds
                            if (!paused) begin
                                if (base + 1 >= positions) begin
                                    base   = 0;
                                    d.done = 1'b1;
                                end
                                else begin
                                    base++;
                                end
                            end
                        end
                    end
                end
                OP_LOAD: line_copy[addr] = dat;
                OP_SPEED: begin
                    if (dat == SPD_DEC) begin
                        if (speed > spd_min)
                            speed = (speed > spd_step) ? speed - spd_step : 0;
                    end
                    else if (dat == SPD_INC) begin
                        if (speed < spd_max) begin
                            speed += spd_step;
                            if (speed > 255)
                                speed = 255;
                        end
                    end
                end
                OP_RUN: begin
                    if (dat == RUN_STOP)
                        paused = 1'b1;
                    else if (dat == RUN_RESUME)
                        paused = 1'b0;
                end
                default: ;
            endcase
            drive_queue.push_back(d);
        endfunction

        function void flag(string what, column_drive_t want, column_drive_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%t %s: want en=%0d sel=%0d lvl=%0d rows=%02h pos=%0d done=%0d",
                         $time, what, want.en, want.sel, want.lvl, want.rows, want.pos,
                         want.done, "\n    got  en=%0d sel=%0d lvl=%0d rows=%02h pos=%0d done=%0d",
                         got.en, got.sel, got.lvl, got.rows, got.pos, got.done);
        endfunction

        function void check_beat(column_drive_t got);
            column_drive_t want;
            if (drive_queue.size() == 0) begin
                flag("result beat with nothing expected", '0, got);
                return;
            end
            want = drive_queue.pop_front();
            if (got.en !== want.en || got.sel !== want.sel || got.lvl !== want.lvl ||
                got.rows !== want.rows || got.pos !== want.pos || got.done !== want.done)
                flag("result beat mismatch", want, got);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           op;
    logic [BYTE_W-1:0]    address;
    logic [BYTE_W-1:0]    data;
    logic                 out_valid;
    logic                 out_ready;
    logic                 column_enable;
    logic [COL_W-1:0]     column_select;
    logic                 column_level;
    logic [BYTE_W-1:0]    row_bits;
    logic [BYTE_W-1:0]    scroll_position;
    logic                 sequence_done;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;

    scan_tracker sb = new();
    bit          stored [DEFAULT_LINE_DEPTH];
    int unsigned tx_left, rx_left;
    bit          tx_calm, rx_calm;
    int unsigned beats_seen;

    led_matrix_scroll_scanner_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .address         (address),
        .data            (data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .column_enable   (column_enable),
        .column_select   (column_select),
        .column_level    (column_level),
        .row_bits        (row_bits),
        .scroll_position (scroll_position),
        .sequence_done   (sequence_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // per-beat wait; runs of calm stretches with no idling at all
    function automatic int unsigned draw_wait(ref int unsigned left, ref bit calm);
        if (left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(16, 64);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic send_item(op_t kind, logic [BYTE_W-1:0] addr, logic [BYTE_W-1:0] dat);
        int unsigned gap;
        gap = draw_wait(tx_left, tx_calm);
        cfg_valid <= 1'b0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= kind;
        address  <= addr;
        data     <= dat;
        do @(posedge clk); while (!in_ready);
        sb.note_item(kind, addr, dat);
        if (kind == OP_LOAD)
            stored[addr] = 1'b1;
    endtask

    task automatic send_random();
        int unsigned       pick;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] d;
        pick = $urandom_range(0, 99);
        a    = BYTE_W'($urandom);
        d    = BYTE_W'($urandom);
        if (pick < 72) begin
            send_item(OP_TICK, a, d);
        end
        else if (pick < 80) begin
            send_item(OP_LOAD, a, d);
        end
        else if (pick < 91) begin
            // steer repeat count low so the scroll actually wraps
            if (pick != 90) begin
                if (sb.speed + sb.spd_step > 12 && $urandom_range(0, 6) != 0)
                    d = SPD_DEC;
                else
                    d = $urandom_range(0, 1) ? SPD_INC : SPD_DEC;
            end
            send_item(OP_SPEED, a, d);
        end
        else begin
            if (pick != 99)
                d = ($urandom_range(0, 2) == 0) ? RUN_STOP : RUN_RESUME;
            send_item(OP_RUN, a, d);
        end
    endtask

    // every position that a tick may show has to hold a loaded byte
    task automatic fill_line(int unsigned len_code);
        int unsigned span;
        span = sb.shown_len(len_code);
        for (int unsigned i = 0; i < span; i++)
            if (!stored[i])
                send_item(OP_LOAD, 8'(i), 8'($urandom));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [LEN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    initial
    begin : stimulus
        logic [LEN_W-1:0]  len;
        logic              pg;
        logic              lvl;
        logic [BYTE_W-1:0] mn;
        logic [BYTE_W-1:0] mx;
        logic [BYTE_W-1:0] st;
        logic [BYTE_W-1:0] pattern [8];

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        op        <= OP_TICK;
        address   <= '0;
        data      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_LINE_LENGTH;
        cfg_data  <= '0;
        pattern   = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h3C, 8'hC3};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default length, extremes of address and data, every command
        for (int i = 0; i < 8; i++)
            send_item(OP_LOAD, 8'(i), pattern[i]);
        send_item(OP_LOAD, 8'hFF, 8'hFF);
        send_item(OP_TICK, 8'hFF, 8'hFF);
        send_item(OP_SPEED, 8'h00, SPD_INC);
        send_item(OP_SPEED, 8'h00, SPD_DEC);
        send_item(OP_SPEED, 8'h00, 8'hFF);
        send_item(OP_RUN, 8'h00, RUN_STOP);
        repeat (3) send_item(OP_TICK, 8'h00, 8'h00);
        send_item(OP_RUN, 8'h00, 8'h80);
        send_item(OP_RUN, 8'h00, RUN_RESUME);
        repeat (6) send_item(OP_TICK, 8'h00, 8'h00);

        for (int p = 0; p < 13; p++) begin
            case (p)
                0: begin
                    len = 9'd1;    pg = 1'b0; mn = 8'd0;   mx = 8'd255; st = 8'd255; lvl = 1'b1;
                end
                1: begin
                    len = 9'd256;  pg = 1'b1; mn = 8'd255; mx = 8'd0;   st = 8'd1;   lvl = 1'b0;
                end
                2: begin
                    len = 9'd0;    pg = 1'b1; mn = 8'd0;   mx = 8'd4;   st = 8'd255; lvl = 1'b1;
                end
                3: begin
                    len = 9'h1FF;  pg = 1'b0; mn = 8'd0;   mx = 8'd50;  st = 8'd2;   lvl = 1'b0;
                end
                default: begin
                    len = ($urandom_range(0, 5) == 0) ? LEN_W'($urandom_range(0, 511))
                                                       : LEN_W'($urandom_range(1, 24));
                    pg  = 1'($urandom_range(0, 1));
                    mn  = BYTE_W'($urandom_range(0, 2));
                    mx  = BYTE_W'($urandom_range(4, 255));
                    st  = ($urandom_range(0, 5) == 0) ? BYTE_W'($urandom_range(1, 255))
                                                       : BYTE_W'($urandom_range(1, 4));
                    lvl = 1'($urandom_range(0, 1));
                end
            endcase
            fill_line(len);
            wait_idle();
            cfg_write(CFG_LINE_LENGTH, len);
            cfg_write(CFG_PAGE_MODE, {8'd0, pg});
            cfg_write(CFG_SPEED_MIN, {1'b0, mn});
            cfg_write(CFG_SPEED_MAX, {1'b0, mx});
            cfg_write(CFG_SPEED_STEP, {1'b0, st});
            cfg_write(CFG_ACT_LEVEL, {8'd0, lvl});
            repeat (80) send_random();
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("led_matrix_scroll_scanner_core regression: pass");
        else
            $display("led_matrix_scroll_scanner_core regression: fail");
        $finish;
    end

    initial
    begin : drain
        int unsigned   stall;
        column_drive_t got;
        out_ready  <= 1'b0;
        beats_seen = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = draw_wait(rx_left, rx_calm);
            // long hold-off so the core backs up and stalls its input
            if (beats_seen == 300 || beats_seen == 900)
                stall = 250;
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got = {column_enable, column_select, column_level, row_bits,
                   scroll_position, sequence_done};
            sb.check_beat(got);
            beats_seen++;
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("led_matrix_scroll_scanner_core regression: fail");
        $finish;
    end

endmodule
